### design/dqpi_pkg.sv
// ----------------------------------------------------------------------------
// dqpi_pkg
// Types, constants and saturating helpers for the d/q current PI controller.
// ----------------------------------------------------------------------------
package dqpi_pkg;

    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 32;

    localparam logic [CfgIdxW-1:0] CFG_KP         = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_KI_DT      = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_IND_D      = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_IND_Q      = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_FLUX       = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_DUTY_LIMIT = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_D_PRIORITY = 3'd6;
    localparam logic [CfgIdxW-1:0] CFG_DECOUPLE   = 3'd7;

    localparam logic [1:0] FN_RUN     = 2'd0;
    localparam logic [1:0] FN_PRELOAD = 2'd1;
    localparam logic [1:0] FN_RESET   = 2'd2;

    localparam logic [15:0] DUTY_MAX = 16'd64225;
    localparam logic [16:0] PRIO_MAX = 17'd65536;
    localparam logic [30:0] BUS_MIN  = 31'd32768;
    localparam logic [31:0] INV_SQRT3_Q32 = 32'd2479700525;

    // micro-step codes of the shared multiplier sequence
    typedef enum logic [3:0] {
        ST_KI_D  = 4'd0,
        ST_KI_Q  = 4'd1,
        ST_KP_D  = 4'd2,
        ST_KP_Q  = 4'd3,
        ST_FFD1  = 4'd4,
        ST_FFD2  = 4'd5,
        ST_FFQ1  = 4'd6,
        ST_FFQ2  = 4'd7,
        ST_FFQ3  = 4'd8,
        ST_VM1   = 4'd9,
        ST_VM2   = 4'd10,
        ST_VDMAX = 4'd11,
        ST_VSQ   = 4'd12,
        ST_VDSQ  = 4'd13
    } step_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        logic signed [31:0] r;
        if (x > 66'sd2147483647) r = 32'sh7fffffff;
        else if (x < -66'sd2147483648) r = 32'sh80000000;
        else r = x[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] clamp_abs(input logic signed [31:0] x,
                                                     input logic [31:0] lim);
        logic signed [33:0] xs;
        logic signed [33:0] ls;
        logic signed [31:0] r;
        xs = 34'(x);
        ls = $signed({2'b00, lim});
        if (xs > ls) r = lim;
        else if (xs < -ls) r = 32'(-ls);
        else r = x;
        return r;
    endfunction

endpackage

### design/dqpi_if.sv
// ----------------------------------------------------------------------------
// dqpi_if
// Valid/ready channels for command and response transactions.
// ----------------------------------------------------------------------------
interface dqpi_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic signed [31:0] ref_d;
    logic signed [31:0] ref_q;
    logic signed [31:0] meas_d;
    logic signed [31:0] meas_q;
    logic signed [31:0] speed_e;
    logic [30:0]        bus_volts;
    logic signed [31:0] want_vd;
    logic signed [31:0] want_vq;

    modport source (output valid, func, ref_d, ref_q, meas_d, meas_q, speed_e,
                    bus_volts, want_vd, want_vq, input ready);
    modport sink   (input valid, func, ref_d, ref_q, meas_d, meas_q, speed_e,
                    bus_volts, want_vd, want_vq, output ready);
endinterface

interface dqpi_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] volt_d;
    logic signed [31:0] volt_q;
    logic               sat_flag;
    logic [30:0]        vmax;
    logic [30:0]        vq_limit;

    modport source (output valid, volt_d, volt_q, sat_flag, vmax, vq_limit,
                    input ready);
    modport sink   (input valid, volt_d, volt_q, sat_flag, vmax, vq_limit,
                     output ready);
endinterface

### design/dq_current_pi_controller.sv
// ----------------------------------------------------------------------------
// dq_current_pi_controller
// d/q PI current controller, Q16.16, with feed-forward and voltage limiting.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  cmd     | in  | valid/ready   | func, currents, speed, bus, preload volts
//  rsp     | out | valid/ready   | volt_d, volt_q, sat_flag, vmax, vq_limit
//  cfg     | in  | cfg_we only   | cfg_index, cfg_data
//
//  Run: 14 multiplies on one 33x33 multiplier, each a multiply and a use
//  state, then a bit-pair square root. Preload: the proportional and
//  feed-forward multiplies only. Reset and unused codes go straight to
//  the response. One transaction in flight; cmd.ready is low while busy.
//  A stalled response waits in its own register; reset spares datapath regs.
// ----------------------------------------------------------------------------
module dq_current_pi_controller (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [dqpi_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [dqpi_pkg::CfgDataW-1:0] cfg_data,
    dqpi_cmd_if.sink                      cmd,
    dqpi_rsp_if.source                    rsp
);
    import dqpi_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_USE  = 6'b000100,
        S_ROOT = 6'b001000,
        S_FIN  = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t state_reg;
    step_t  step_reg;

    logic [30:0] kp_reg, ki_reg;
    logic [31:0] ind_d_reg, ind_q_reg, flux_reg;
    logic [15:0] duty_reg;
    logic [16:0] prio_reg;
    logic        dec_reg;

    logic [1:0]         func_reg;
    logic signed [31:0] ed_reg, eq_reg, w_reg, md_reg, mq_reg, wd_reg, wq_reg;
    logic [30:0]        bus_reg;

    logic signed [31:0] integ_d_reg, integ_q_reg;
    logic signed [31:0] held_vd_reg, held_vq_reg;
    logic               held_sat_reg;
    logic [30:0]        held_vmax_reg, held_vqlim_reg;

    logic signed [31:0] id_reg, iq_reg, vd_reg, vq_reg, t_reg, ffd_reg, ffq_reg, vdc_reg;
    logic [30:0]        vmax_reg;
    logic [63:0]        rad_reg, root_reg;
    logic [4:0]         cnt_reg;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_reg;

    logic               out_valid_reg;
    logic signed [31:0] out_vd_reg, out_vq_reg;
    logic               out_sat_reg;
    logic [30:0]        out_vmax_reg, out_vqlim_reg;

    logic               accept;
    logic signed [31:0] ms16, ms32, ffq_sum, vqc;
    logic [31:0]        vdmax, vqmax;
    logic [63:0]        bit_val, trial;

    assign accept = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == S_IDLE);

    assign ms16 = sat32(prod_reg >>> 16);
    assign ms32 = sat32(prod_reg >>> 32);
    assign ffq_sum = dec_reg ? sat32(66'(ffq_reg) + 66'(ms32)) : 32'sd0;
    assign vdmax = {1'b0, prod_reg[46:16]};
    assign vqmax = root_reg[31:0];
    assign vqc = clamp_abs(vq_reg, vqmax);
    assign bit_val = 64'd1 << {cnt_reg, 1'b0};
    assign trial = root_reg + bit_val;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            ST_KI_D:  begin mul_a = 33'(ed_reg); mul_b = $signed({2'b00, ki_reg}); end
            ST_KI_Q:  begin mul_a = 33'(eq_reg); mul_b = $signed({2'b00, ki_reg}); end
            ST_KP_D:  begin mul_a = 33'(ed_reg); mul_b = $signed({2'b00, kp_reg}); end
            ST_KP_Q:  begin mul_a = 33'(eq_reg); mul_b = $signed({2'b00, kp_reg}); end
            ST_FFD1:  begin mul_a = 33'(w_reg);  mul_b = $signed({1'b0, ind_q_reg}); end
            ST_FFD2:  begin mul_a = 33'(t_reg);  mul_b = 33'(mq_reg); end
            ST_FFQ1:  begin mul_a = 33'(w_reg);  mul_b = $signed({1'b0, ind_d_reg}); end
            ST_FFQ2:  begin mul_a = 33'(t_reg);  mul_b = 33'(md_reg); end
            ST_FFQ3:  begin mul_a = 33'(w_reg);  mul_b = $signed({1'b0, flux_reg}); end
            ST_VM1:   begin mul_a = $signed({17'd0, duty_reg}); mul_b = $signed({2'b00, bus_reg}); end
            ST_VM2:   begin mul_a = 33'(t_reg);  mul_b = $signed({1'b0, INV_SQRT3_Q32}); end
            ST_VDMAX: begin mul_a = $signed({2'b00, vmax_reg}); mul_b = $signed({16'd0, prio_reg}); end
            ST_VSQ:   begin mul_a = $signed({2'b00, vmax_reg}); mul_b = $signed({2'b00, vmax_reg}); end
            ST_VDSQ:  begin mul_a = 33'(vdc_reg); mul_b = 33'(vdc_reg); end
            default:  begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg    <= '0;
            ki_reg    <= '0;
            ind_d_reg <= '0;
            ind_q_reg <= '0;
            flux_reg  <= '0;
            duty_reg  <= '0;
            prio_reg  <= '0;
            dec_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_KP:         kp_reg <= cfg_data[30:0];
                CFG_KI_DT:      ki_reg <= cfg_data[30:0];
                CFG_IND_D:      ind_d_reg <= cfg_data;
                CFG_IND_Q:      ind_q_reg <= cfg_data;
                CFG_FLUX:       flux_reg <= cfg_data;
                CFG_DUTY_LIMIT: duty_reg <= (cfg_data[15:0] > DUTY_MAX) ? DUTY_MAX : cfg_data[15:0];
                CFG_D_PRIORITY: prio_reg <= (cfg_data[16:0] > PRIO_MAX) ? PRIO_MAX : cfg_data[16:0];
                CFG_DECOUPLE:   dec_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= cmd.func;
            ed_reg   <= sat32(66'(cmd.ref_d) - 66'(cmd.meas_d));
            eq_reg   <= sat32(66'(cmd.ref_q) - 66'(cmd.meas_q));
            w_reg    <= cmd.speed_e;
            md_reg   <= cmd.meas_d;
            mq_reg   <= cmd.meas_q;
            bus_reg  <= cmd.bus_volts;
            wd_reg   <= cmd.want_vd;
            wq_reg   <= cmd.want_vq;
        end
        if (state_reg == S_MUL)
            prod_reg <= mul_a * mul_b;
        if (state_reg == S_USE)
        begin
            case (step_reg)
                ST_KI_D: id_reg <= sat32(66'(integ_d_reg) + 66'(ms16));
                ST_KI_Q: iq_reg <= sat32(66'(integ_q_reg) + 66'(ms16));
                ST_KP_D: vd_reg <= (func_reg == FN_RUN) ? sat32(66'(id_reg) + 66'(ms16))
                                                        : sat32(66'(wd_reg) - 66'(ms16));
                ST_KP_Q: vq_reg <= (func_reg == FN_RUN) ? sat32(66'(iq_reg) + 66'(ms16))
                                                        : sat32(66'(wq_reg) - 66'(ms16));
                ST_FFD1: t_reg <= ms32;
                ST_FFD2: ffd_reg <= dec_reg ? ms16 : 32'sd0;
                ST_FFQ1: t_reg <= ms32;
                ST_FFQ2: ffq_reg <= ms16;
                ST_FFQ3:
                begin
                    ffq_reg <= ffq_sum;
                    if (func_reg == FN_RUN)
                    begin
                        vd_reg <= sat32(66'(vd_reg) - 66'(ffd_reg));
                        vq_reg <= sat32(66'(vq_reg) + 66'(ffq_sum));
                    end
                end
                ST_VM1:  t_reg <= {1'b0, prod_reg[46:16]};
                ST_VM2:  vmax_reg <= prod_reg[62:32];
                ST_VDMAX:
                begin
                    vdc_reg <= clamp_abs(vd_reg, vdmax);
                    id_reg  <= clamp_abs(id_reg, vdmax);
                end
                ST_VSQ:  rad_reg <= prod_reg[63:0];
                ST_VDSQ:
                begin
                    rad_reg  <= rad_reg - prod_reg[63:0];
                    root_reg <= '0;
                    cnt_reg  <= 5'd31;
                end
                default: ;
            endcase
        end
        if (state_reg == S_ROOT)
        begin
            cnt_reg <= cnt_reg - 5'd1;
            if (rad_reg >= trial)
            begin
                rad_reg  <= rad_reg - trial;
                root_reg <= (root_reg >> 1) + bit_val;
            end
            else
                root_reg <= root_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_reg       <= ST_KI_D;
            integ_d_reg    <= '0;
            integ_q_reg    <= '0;
            held_vd_reg    <= '0;
            held_vq_reg    <= '0;
            held_sat_reg   <= 1'b0;
            held_vmax_reg  <= '0;
            held_vqlim_reg <= '0;
            out_valid_reg  <= 1'b0;
            out_vd_reg     <= '0;
            out_vq_reg     <= '0;
            out_sat_reg    <= 1'b0;
            out_vmax_reg   <= '0;
            out_vqlim_reg  <= '0;
        end
        else
        begin
            if (out_valid_reg && rsp.ready && state_reg != S_OUT)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_OUT;
                        if (cmd.func == FN_RUN)
                        begin
                            if (cmd.bus_volts <= BUS_MIN)
                            begin
                                held_vd_reg  <= '0;
                                held_vq_reg  <= '0;
                                held_sat_reg <= 1'b1;
                            end
                            else
                            begin
                                step_reg  <= ST_KI_D;
                                state_reg <= S_MUL;
                            end
                        end
                        else if (cmd.func == FN_PRELOAD)
                        begin
                            step_reg  <= ST_KP_D;
                            state_reg <= S_MUL;
                        end
                        else if (cmd.func == FN_RESET)
                        begin
                            integ_d_reg    <= '0;
                            integ_q_reg    <= '0;
                            held_vd_reg    <= '0;
                            held_vq_reg    <= '0;
                            held_sat_reg   <= 1'b0;
                            held_vmax_reg  <= '0;
                            held_vqlim_reg <= '0;
                        end
                    end
                end
                S_MUL: state_reg <= S_USE;
                S_USE:
                begin
                    if (step_reg == ST_VDSQ)
                        state_reg <= S_ROOT;
                    else if (step_reg == ST_FFQ3 && func_reg == FN_PRELOAD)
                        state_reg <= S_FIN;
                    else
                    begin
                        step_reg  <= step_t'(step_reg + 4'd1);
                        state_reg <= S_MUL;
                    end
                end
                S_ROOT:
                begin
                    if (cnt_reg == 5'd0)
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    state_reg <= S_OUT;
                    if (func_reg == FN_PRELOAD)
                    begin
                        integ_d_reg <= sat32(66'(vd_reg) + 66'(ffd_reg));
                        integ_q_reg <= sat32(66'(vq_reg) - 66'(ffq_reg));
                    end
                    else
                    begin
                        integ_d_reg    <= id_reg;
                        integ_q_reg    <= clamp_abs(iq_reg, vqmax);
                        held_vd_reg    <= vdc_reg;
                        held_vq_reg    <= vqc;
                        held_sat_reg   <= (vdc_reg != vd_reg) || (vqc != vq_reg);
                        held_vmax_reg  <= vmax_reg;
                        held_vqlim_reg <= vqmax[30:0];
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_vd_reg    <= held_vd_reg;
                        out_vq_reg    <= held_vq_reg;
                        out_sat_reg   <= held_sat_reg;
                        out_vmax_reg  <= held_vmax_reg;
                        out_vqlim_reg <= held_vqlim_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.volt_d   = out_vd_reg;
    assign rsp.volt_q   = out_vq_reg;
    assign rsp.sat_flag = out_sat_reg;
    assign rsp.vmax     = out_vmax_reg;
    assign rsp.vq_limit = out_vqlim_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !cmd.ready)
        else $error("cmd accepted while busy");

    a_root_only_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROOT) |-> (func_reg == FN_RUN))
        else $error("square root entered outside run");

    a_fin_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |=> (state_reg == S_OUT))
        else $error("finish did not hand off to response");

    a_out_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && (!out_valid_reg || rsp.ready)) |=> rsp.valid)
        else $error("response not presented");

endmodule

### dv/dq_current_pi_controller_tb.sv
// ----------------------------------------------------------------------------
// dq_current_pi_controller_tb
// Drives run, preload, reset and spare-code transactions into the d/q PI controller
// under several gain and limit settings, predicts every response in fixed point and
// compares it field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dq_current_pi_controller_tb;
    import dqpi_pkg::*;

    localparam logic [1:0] FN_SPARE = 2'd3;

    typedef struct packed {
        logic signed [31:0] vd;
        logic signed [31:0] vq;
        logic               sat;
        logic [30:0]        vm;
        logic [30:0]        vql;
    } volt_cmd_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CfgIdxW-1:0] cfg_index;
    logic [CfgDataW-1:0] cfg_data;

    dqpi_cmd_if cmd();
    dqpi_rsp_if rsp();

    dq_current_pi_controller uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .cmd(cmd), .rsp(rsp)
    );

    // controller model state
    logic [30:0] m_kp, m_ki;
    logic [31:0] m_ind_d, m_ind_q, m_flux;
    logic [15:0] m_duty;
    logic [16:0] m_prio;
    logic        m_dec;
    logic signed [31:0] m_int_d, m_int_q;
    volt_cmd_t held;

    volt_cmd_t expected_cmds[$];
    int  errors;
    int  idle_cycles;
    bit  quiet;
    int  hold_rsp;
    int  rsp_gap;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint sat_w(input longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // exact product, floor shift, saturate
    function automatic longint mul_shift(input longint a, input longint b, input int n);
        logic signed [127:0] p;
        logic signed [127:0] q;
        p = 128'(a) * 128'(b);
        q = p >>> n;
        if (q > 128'sd2147483647) return 64'sd2147483647;
        if (q < -128'sd2147483648) return -64'sd2147483648;
        return longint'(q);
    endfunction

    function automatic longint lim_abs(input longint x, input longint l);
        if (x > l) return l;
        if (x < -l) return -l;
        return x;
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    task automatic feed_fwd(input longint w, input longint id, input longint iq,
                            output longint fd, output longint fq);
        fd = 0;
        fq = 0;
        if (m_dec)
        begin
            fd = mul_shift(mul_shift(w, longint'(m_ind_q), 32), iq, 16);
            fq = sat_w(mul_shift(mul_shift(w, longint'(m_ind_d), 32), id, 16)
                       + mul_shift(w, longint'(m_flux), 32));
        end
    endtask

    task automatic predict_voltage(input logic [1:0] fn, input logic signed [31:0] rd,
                                   input logic signed [31:0] rq,
                                   input logic signed [31:0] md,
                                   input logic signed [31:0] mq,
                                   input logic signed [31:0] w,
                                   input logic [30:0] bus,
                                   input logic signed [31:0] wvd,
                                   input logic signed [31:0] wvq);
        longint ed, eq, fd, fq, idn, iqn, vd, vq, vdc, vqc;
        longint unsigned vm, vdm, vqm;
        ed = sat_w(longint'(rd) - longint'(md));
        eq = sat_w(longint'(rq) - longint'(mq));
        if (fn == FN_RUN)
        begin
            if (bus <= BUS_MIN)
            begin
                held.vd = 0;
                held.vq = 0;
                held.sat = 1'b1;
            end
            else
            begin
                idn = sat_w(longint'(m_int_d) + mul_shift(ed, longint'(m_ki), 16));
                iqn = sat_w(longint'(m_int_q) + mul_shift(eq, longint'(m_ki), 16));
                vd = sat_w(idn + mul_shift(ed, longint'(m_kp), 16));
                vq = sat_w(iqn + mul_shift(eq, longint'(m_kp), 16));
                feed_fwd(w, md, mq, fd, fq);
                vd = sat_w(vd - fd);
                vq = sat_w(vq + fq);
                vm = (((64'(m_duty) * 64'(bus)) >> 16) * 64'(INV_SQRT3_Q32)) >> 32;
                vdm = (vm * 64'(m_prio)) >> 16;
                vdc = lim_abs(vd, longint'(vdm));
                idn = lim_abs(idn, longint'(vdm));
                vqm = root_floor(vm * vm - longint'(vdc * vdc));
                vqc = lim_abs(vq, longint'(vqm));
                iqn = lim_abs(iqn, longint'(vqm));
                m_int_d = idn[31:0];
                m_int_q = iqn[31:0];
                held.vd = vdc[31:0];
                held.vq = vqc[31:0];
                held.sat = (vdc != vd) || (vqc != vq);
                held.vm = vm[30:0];
                held.vql = vqm[30:0];
            end
        end
        else if (fn == FN_PRELOAD)
        begin
            feed_fwd(w, md, mq, fd, fq);
            m_int_d = 32'(sat_w(sat_w(longint'(wvd) - mul_shift(ed, longint'(m_kp), 16)) + fd));
            m_int_q = 32'(sat_w(sat_w(longint'(wvq) - mul_shift(eq, longint'(m_kp), 16)) - fq));
        end
        else if (fn == FN_RESET)
        begin
            m_int_d = 0;
            m_int_q = 0;
            held = '0;
        end
        expected_cmds.push_back(held);
    endtask

    task automatic set_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_KP:         m_kp = val[30:0];
            CFG_KI_DT:      m_ki = val[30:0];
            CFG_IND_D:      m_ind_d = val;
            CFG_IND_Q:      m_ind_q = val;
            CFG_FLUX:       m_flux = val;
            CFG_DUTY_LIMIT: m_duty = (val[15:0] > DUTY_MAX) ? DUTY_MAX : val[15:0];
            CFG_D_PRIORITY: m_prio = (val[16:0] > PRIO_MAX) ? PRIO_MAX : val[16:0];
            default:        m_dec = val[0];
        endcase
    endtask

    task automatic wait_drained();
        while (expected_cmds.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [30:0] kp, input logic [30:0] ki,
                                  input logic [31:0] ld, input logic [31:0] lq,
                                  input logic [31:0] fl, input logic [15:0] du,
                                  input logic [16:0] pr, input logic dc);
        wait_drained();
        set_reg(CFG_KP, 32'(kp));
        set_reg(CFG_KI_DT, 32'(ki));
        set_reg(CFG_IND_D, ld);
        set_reg(CFG_IND_Q, lq);
        set_reg(CFG_FLUX, fl);
        set_reg(CFG_DUTY_LIMIT, 32'(du));
        set_reg(CFG_D_PRIORITY, 32'(pr));
        set_reg(CFG_DECOUPLE, 32'(dc));
    endtask

    task automatic send_cmd(input logic [1:0] fn, input logic signed [31:0] rd,
                            input logic signed [31:0] rq, input logic signed [31:0] md,
                            input logic signed [31:0] mq, input logic signed [31:0] w,
                            input logic [30:0] bus, input logic signed [31:0] wvd,
                            input logic signed [31:0] wvq);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            cmd.valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        cmd.valid = 1'b1;
        cmd.func = fn;
        cmd.ref_d = rd;
        cmd.ref_q = rq;
        cmd.meas_d = md;
        cmd.meas_q = mq;
        cmd.speed_e = w;
        cmd.bus_volts = bus;
        cmd.want_vd = wvd;
        cmd.want_vq = wvq;
        @(posedge clk);
        while (!cmd.ready) @(posedge clk);
        predict_voltage(fn, rd, rq, md, mq, w, bus, wvd, wvq);
        @(negedge clk);
        cmd.valid = 1'b0;
    endtask

    function automatic logic signed [31:0] rnd_amps();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $signed($urandom_range(0, 32'h000a0000)) - 32'sh00050000;
            default: return $signed($urandom_range(0, 32'h01400000)) - 32'sh00a00000;
        endcase
    endfunction

    function automatic logic [30:0] rnd_bus();
        case ($urandom_range(0, 7))
            0: return 31'($urandom_range(0, 32768));
            1: return 31'($urandom());
            default: return 31'($urandom_range(32'h00080000, 32'h00640000));
        endcase
    endfunction

    task automatic send_random();
        int r;
        logic [1:0] fn;
        r = $urandom_range(0, 19);
        fn = (r < 15) ? FN_RUN : (r < 18) ? FN_PRELOAD : (r == 18) ? FN_RESET : FN_SPARE;
        send_cmd(fn, rnd_amps(), rnd_amps(), rnd_amps(), rnd_amps(), rnd_amps(),
                 rnd_bus(), rnd_amps(), rnd_amps());
    endtask

    task automatic test_directed();
        send_cmd(FN_RUN, 32'sh00010000, 32'sh00020000, 0, 0, 0, 31'h00300000, 0, 0);
        send_cmd(FN_RUN, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
                 32'sh7fffffff, 31'h7fffffff, 0, 0);
        send_cmd(FN_RUN, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
                 32'sh80000000, 31'h7fffffff, 0, 0);
        send_cmd(FN_RUN, 32'sh00050000, 32'sh00050000, 0, 0, 32'sh00100000,
                 31'd32768, 0, 0);
        send_cmd(FN_RUN, 32'sh00050000, 32'sh00050000, 0, 0, 0, 31'd32769, 0, 0);
        send_cmd(FN_RUN, 0, 0, 0, 0, 0, 31'd0, 0, 0);
        send_cmd(FN_PRELOAD, 32'sh00010000, -32'sh00010000, 0, 32'sh00008000,
                 32'sh00200000, 31'd0, 32'sh00040000, -32'sh00030000);
        send_cmd(FN_RUN, 32'sh00010000, -32'sh00010000, 0, 32'sh00008000,
                 32'sh00200000, 31'h00300000, 0, 0);
        send_cmd(FN_PRELOAD, 0, 0, 0, 0, 0, 31'd0, 32'sh7fffffff, 32'sh80000000);
        send_cmd(FN_RUN, 0, 0, 0, 0, 0, 31'h00300000, 0, 0);
        send_cmd(FN_SPARE, 32'sh00010000, 0, 0, 0, 0, 31'h00300000, 0, 0);
        send_cmd(FN_RESET, 0, 0, 0, 0, 0, 31'd0, 0, 0);
        send_cmd(FN_RUN, -32'sh00030000, 32'sh00030000, 0, 0, -32'sh00400000,
                 31'h00180000, 0, 0);
    endtask

    task automatic test_random(input int n);
        repeat (n) send_random();
    endtask

    task automatic test_backpressure();
        hold_rsp = 300;
        repeat (8) send_random();
    endtask

    // response side: random stall bursts, long hold-off when requested
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            rsp_gap <= 0;
        end
        else if (hold_rsp > 0)
        begin
            hold_rsp <= hold_rsp - 1;
            rsp.ready <= 1'b0;
        end
        else if (rsp_gap > 0)
        begin
            rsp_gap <= rsp_gap - 1;
            rsp.ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            rsp_gap <= $urandom_range(0, 14);
            rsp.ready <= 1'b0;
        end
        else rsp.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        volt_cmd_t exp_v;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_cmds.size() == 0)
            begin
                $display("%0t: unexpected response vd=%h vq=%h", $time,
                         rsp.volt_d, rsp.volt_q);
                errors++;
            end
            else
            begin
                exp_v = expected_cmds.pop_front();
                if (rsp.volt_d !== exp_v.vd)
                begin
                    $display("%0t: volt_d exp %h got %h", $time, exp_v.vd, rsp.volt_d);
                    errors++;
                end
                if (rsp.volt_q !== exp_v.vq)
                begin
                    $display("%0t: volt_q exp %h got %h", $time, exp_v.vq, rsp.volt_q);
                    errors++;
                end
                if (rsp.sat_flag !== exp_v.sat)
                begin
                    $display("%0t: sat_flag exp %b got %b", $time, exp_v.sat,
                             rsp.sat_flag);
                    errors++;
                end
                if (rsp.vmax !== exp_v.vm)
                begin
                    $display("%0t: vmax exp %h got %h", $time, exp_v.vm, rsp.vmax);
                    errors++;
                end
                if (rsp.vq_limit !== exp_v.vql)
                begin
                    $display("%0t: vq_limit exp %h got %h", $time, exp_v.vql,
                             rsp.vq_limit);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 3000)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cmd.valid = 1'b0;
        cmd.func = FN_RUN;
        cmd.ref_d = 0;
        cmd.ref_q = 0;
        cmd.meas_d = 0;
        cmd.meas_q = 0;
        cmd.speed_e = 0;
        cmd.bus_volts = '0;
        cmd.want_vd = 0;
        cmd.want_vq = 0;
        errors = 0;
        idle_cycles = 0;
        quiet = 1'b0;
        hold_rsp = 0;
        m_kp = 0; m_ki = 0; m_ind_d = 0; m_ind_q = 0; m_flux = 0;
        m_duty = 0; m_prio = 0; m_dec = 0;
        m_int_d = 0; m_int_q = 0;
        held = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        apply_settings(31'h00020000, 31'h00000800, 32'h00418937, 32'h00624dd3,
                       32'h01000000, 16'hffff, 17'h1ffff, 1'b1);
        test_directed();
        test_random(250);
        apply_settings(31'h7fffffff, 31'h7fffffff, 32'hffffffff, 32'hffffffff,
                       32'hffffffff, DUTY_MAX, PRIO_MAX, 1'b1);
        test_directed();
        test_random(150);
        apply_settings(31'h00008000, 31'h00000100, 32'h00100000, 32'h00200000,
                       32'h00800000, 16'd32768, 17'd45875, 1'b0);
        test_backpressure();
        test_random(250);
        apply_settings(31'($urandom()), 31'($urandom_range(0, 32'h00010000)),
                       $urandom(), $urandom(), $urandom(), 16'($urandom()),
                       17'($urandom()), 1'($urandom()));
        test_random(200);
        quiet = 1'b1;
        test_random(150);
        wait_drained();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
